// ===== rtl/imrm_pkg.sv =====
// ----------------------------------------------------------------------------
// imrm_pkg
// Shared types and sizes for the integer matrix row multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package imrm_pkg;

	// Matrix sizes: inner dimension (elements per A row, rows of B) and
	// result columns (columns of B, elements per C row).
	localparam int N_DIM  = 4;
	localparam int N_COLS = 4;

	// Element and result widths
	localparam int ELEM_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int OUT_W  = 34;
	localparam int ROW_W  = $clog2(N_DIM);

	// Item command codes
	typedef enum logic [0:0] {
		CMD_LOAD = 1'b0,
		CMD_MUL  = 1'b1
	} cmd_t;

	// Pipeline stage advance controls from the top level to the lanes
	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
	} pipe_ctl_t;

endpackage : imrm_pkg

`default_nettype wire

// ===== rtl/imrm_req_if.sv =====
// ----------------------------------------------------------------------------
// imrm_req_if
// Input item channel: a B row load or an A row multiply.
// ----------------------------------------------------------------------------
`default_nettype none

interface imrm_req_if import imrm_pkg::*; ();

	logic                     valid;
	logic                     ready;
	cmd_t                     cmd;
	logic [ROW_W-1:0]         b_row;
	logic signed [ELEM_W-1:0] v0;
	logic signed [ELEM_W-1:0] v1;
	logic signed [ELEM_W-1:0] v2;
	logic signed [ELEM_W-1:0] v3;

	modport source (output valid, cmd, b_row, v0, v1, v2, v3, input ready);
	modport sink   (input valid, cmd, b_row, v0, v1, v2, v3, output ready);

endinterface : imrm_req_if

`default_nettype wire

// ===== rtl/imrm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// imrm_rsp_if
// Result item channel: one row of C.
// ----------------------------------------------------------------------------
`default_nettype none

interface imrm_rsp_if import imrm_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] c0;
	logic signed [OUT_W-1:0] c1;
	logic signed [OUT_W-1:0] c2;
	logic signed [OUT_W-1:0] c3;

	modport source (output valid, c0, c1, c2, c3, input ready);
	modport sink   (input valid, c0, c1, c2, c3, output ready);

endinterface : imrm_rsp_if

`default_nettype wire

// ===== rtl/integer_matrix_row_multiply.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_row_multiply
// Row-by-matrix multiply C = A x B with a stored 4x4 signed 16-bit B.
// ----------------------------------------------------------------------------
// Load B one row per item with cmd CMD_LOAD (no result), then send rows of
// A with cmd CMD_MUL; each gives one row of C, every element a full 34-bit
// signed dot product. Every B entry must be loaded before a multiply reads
// it. The block takes one item per cycle unless stalled: four column lanes each
// register their four products, then their sum, and an output register holds
// the row. The pipeline stalls only while the output register is full and not
// taken. A load takes effect at once for the next item.
`default_nettype none

module integer_matrix_row_multiply import imrm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	imrm_req_if.sink   req,
	imrm_rsp_if.source rsp
);

	logic signed [ELEM_W-1:0] b_q [N_DIM][N_COLS];
	logic signed [ELEM_W-1:0] a_vec [N_DIM];
	logic signed [ELEM_W-1:0] b_col [N_COLS][N_DIM];
	logic signed [OUT_W-1:0]  lane_sum [N_COLS];
	logic                     valid_s1;
	logic                     valid_s2;
	logic                     adv_out;
	logic                     accept;
	pipe_ctl_t                ctl;

	// Stage advance: a stage moves when empty or when the next one moves
	assign ctl.adv_s2 = !valid_s2 || adv_out;
	assign ctl.adv_s1 = !valid_s1 || ctl.adv_s2;
	assign req.ready  = ctl.adv_s1;
	assign accept     = req.valid && req.ready;

	assign a_vec[0] = req.v0;
	assign a_vec[1] = req.v1;
	assign a_vec[2] = req.v2;
	assign a_vec[3] = req.v3;

	// Store a B row on a load item
	always_ff @(posedge clk) begin
		if (accept && req.cmd == CMD_LOAD) begin
			for (int r = 0; r < N_DIM; r++) begin
				if (req.b_row == ROW_W'(r)) begin
					for (int j = 0; j < N_COLS; j++) begin
						b_q[r][j] <= a_vec[j];
					end
				end
			end
		end
	end

	// Track which stages hold a multiply item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ctl.adv_s1) begin
				valid_s1 <= accept && req.cmd == CMD_MUL;
			end
			if (ctl.adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// One lane per result column
	for (genvar j = 0; j < N_COLS; j++) begin : g_lane
		for (genvar k = 0; k < N_DIM; k++) begin : g_col
			assign b_col[j][k] = b_q[k][j];
		end

		imrm_lane u_lane (
			.clk (clk),
			.ctl (ctl),
			.a   (a_vec),
			.b   (b_col[j]),
			.sum (lane_sum[j])
		);
	end

	imrm_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.sum      (lane_sum),
		.adv_out  (adv_out),
		.rsp      (rsp)
	);

	// A load item never enters the multiply pipeline
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd == CMD_LOAD) |=> !valid_s1)
		else $error("load item entered the multiply pipeline");

	// A multiply item always enters the first stage
	a_mul_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd == CMD_MUL) |=> valid_s1)
		else $error("multiply item lost at entry");

	// A stalled second stage keeps its item
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !ctl.adv_s2) |=> valid_s2)
		else $error("stalled item dropped from second stage");

	// An item moves from the first to the second stage when it advances
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ctl.adv_s2) |=> valid_s2)
		else $error("item lost between first and second stage");

endmodule : integer_matrix_row_multiply

`default_nettype wire

// ===== rtl/imrm_lane.sv =====
// ----------------------------------------------------------------------------
// imrm_lane
// One result column: registered products, then a registered sum.
// ----------------------------------------------------------------------------
`default_nettype none

module imrm_lane import imrm_pkg::*; (
	input  wire logic                     clk,
	input  wire pipe_ctl_t                ctl,
	input  wire logic signed [ELEM_W-1:0] a [N_DIM],
	input  wire logic signed [ELEM_W-1:0] b [N_DIM],
	output logic signed [OUT_W-1:0]       sum
);

	logic signed [PROD_W-1:0] prod_s1 [N_DIM];
	logic signed [OUT_W-1:0]  acc;
	logic signed [OUT_W-1:0]  sum_s2;

	// Multiply each A element by its B column entry
	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			for (int k = 0; k < N_DIM; k++) begin
				prod_s1[k] <= a[k] * b[k];
			end
		end
	end

	// Add the sign-extended products
	always_comb begin
		acc = '0;
		for (int k = 0; k < N_DIM; k++) begin
			acc = acc + OUT_W'(prod_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			sum_s2 <= acc;
		end
	end

	assign sum = sum_s2;

endmodule : imrm_lane

`default_nettype wire

// ===== rtl/imrm_merge.sv =====
// ----------------------------------------------------------------------------
// imrm_merge
// Output stage: gathers the lane sums into one result row and holds it
// until the item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module imrm_merge import imrm_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    valid_s2,
	input  wire logic signed [OUT_W-1:0] sum [N_COLS],
	output logic                         adv_out,
	imrm_rsp_if.source                   rsp
);

	logic                    valid_q;
	logic signed [OUT_W-1:0] row_q [N_COLS];

	// Load when empty or when the held item leaves this cycle
	assign adv_out = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv_out) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			row_q <= sum;
		end
	end

	assign rsp.valid = valid_q;
	assign rsp.c0    = row_q[0];
	assign rsp.c1    = row_q[1];
	assign rsp.c2    = row_q[2];
	assign rsp.c3    = row_q[3];

endmodule : imrm_merge

`default_nettype wire
